// ===== hw/rtl/pdrd_pkg.sv =====
// Shared types, result codes and helpers for the packed DNA record decoder.
// No dependencies; every other file of the block imports this package.
package pdrd_pkg;

    localparam int LENGTH_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [7:0] PAD_PATTERN = 8'hAA;

    typedef enum logic [2:0] {
        KIND_START    = 3'd0,
        KIND_BASES    = 3'd1,
        KIND_REF      = 3'd2,
        KIND_CATEGORY = 3'd3,
        KIND_ERROR    = 3'd4,
        KIND_END      = 3'd5
    } kind_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LENGTH    = 3'd1;
    localparam logic [2:0] ERR_CATEGORY  = 3'd2;
    localparam logic [2:0] ERR_PADDING   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    // One classified item on its way from the parser to the output stage.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] length;
        logic        has_ref;
        logic [7:0]  data;
        logic [2:0]  count;
        logic        last;
        logic [7:0]  category;
        logic [31:0] ref_id;
        logic [31:0] ref_pos;
        logic [2:0]  err_code;
    } entry_t;

    // Bits of a packed byte that hold the first count bases.
    function automatic logic [7:0] base_keep_mask(input logic [2:0] count);
        logic [7:0] mask;
        unique case (count)
            3'd0:    mask = 8'h00;
            3'd1:    mask = 8'h03;
            3'd2:    mask = 8'h0F;
            3'd3:    mask = 8'h3F;
            default: mask = 8'hFF;
        endcase
        return mask;
    endfunction

endpackage

// ===== hw/rtl/packed_dna_record_decoder.sv =====
// Top level of the packed DNA record decoder: parser, item queue, output stage.
// Depends on pdrd_pkg, pdrd_front, pdrd_queue and pdrd_back.
//
// The decoder takes one byte of a packed record stream per clock (push while full
// is low) and can keep that pace indefinitely: each byte is parsed as it is taken,
// at most one result is queued for it, and the output register is refilled in the
// same cycle its item is popped. A result passes through the item queue and then
// the output register; full rises only when the four-entry item queue and the
// output register are all occupied because results are not being popped. Only the
// last field byte of a long length, category or reference trailer gives a result.
// After any error result the decoder accepts bytes but produces nothing until reset.
// The limit registers (0 min_length, 1 max_length, 2 max_category) should be
// written only while no item is in flight.
module packed_dna_record_decoder
    import pdrd_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    input  logic               stream_end,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         result_kind,
    output logic [31:0]        read_length,
    output logic               has_reference,
    output logic [7:0]         bases,
    output logic [2:0]         base_count,
    output logic               last_of_read,
    output logic [7:0]         category,
    output logic signed [31:0] reference_id,
    output logic signed [31:0] reference_pos,
    output logic [2:0]         error_code
);

    logic   accept;
    logic   q_push;
    entry_t q_wr_entry;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    entry_t q_rd_entry;

    assign full   = q_full;
    assign accept = push && !q_full;

    pdrd_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .q_push     (q_push),
        .q_entry    (q_wr_entry)
    );

    pdrd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .rd_entry (q_rd_entry)
    );

    pdrd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_entry       (q_rd_entry),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .result_kind   (result_kind),
        .read_length   (read_length),
        .has_reference (has_reference),
        .bases         (bases),
        .base_count    (base_count),
        .last_of_read  (last_of_read),
        .category      (category),
        .reference_id  (reference_id),
        .reference_pos (reference_pos),
        .error_code    (error_code)
    );

endmodule

// ===== hw/rtl/pdrd_front.sv =====
// Byte parser of the packed DNA record decoder: control bytes, length and
// category fields, base bytes and reference trailers. Holds the limit registers.
// Depends on pdrd_pkg.
module pdrd_front
    import pdrd_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        q_push,
    output entry_t      q_entry
);

    typedef enum logic [4:0] {
        PH_CONTROL   = 5'b00001,
        PH_LENGTH    = 5'b00010,
        PH_CATEGORY  = 5'b00100,
        PH_BASES     = 5'b01000,
        PH_REFERENCE = 5'b10000
    } phase_t;

    localparam logic [1:0] CFG_MIN_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_MAX_CATEGORY = 2'd2;

    logic [31:0]             min_len_reg;
    logic [31:0]             max_len_reg;
    logic [7:0]              max_cat_reg;

    phase_t                  phase_reg, phase_next;
    logic [2:0]              idx_reg, idx_next;
    logic [31:0]             acc_reg, acc_next;
    logic [LENGTH_WIDTH-1:0] remaining_reg, remaining_next;
    logic                    ref_flag_reg, ref_flag_next;
    logic [31:0]             saved_id_reg, saved_id_next;
    logic [7:0]              category_reg, category_next;
    logic                    halted_reg, halted_next;

    logic [31:0] acc_merged;
    logic [2:0]  idx_inc;
    logic [2:0]  bases_cnt;
    logic        bases_last;
    logic [7:0]  pad_mask;
    logic        do_start;
    logic [31:0] start_len;
    logic        len_bad;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic        emit;
    entry_t      entry;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_len_reg <= '0;
            max_len_reg <= '1;
            max_cat_reg <= '1;
        end
        else if (cfg_write) begin
            if (cfg_index == CFG_MIN_LENGTH) begin
                min_len_reg <= cfg_data;
            end
            if (cfg_index == CFG_MAX_LENGTH) begin
                max_len_reg <= cfg_data;
            end
            if (cfg_index == CFG_MAX_CATEGORY) begin
                max_cat_reg <= cfg_data[7:0];
            end
        end
    end

    assign acc_merged = acc_reg | (32'(data_byte) << {idx_reg[1:0], 3'b000});
    assign idx_inc    = idx_reg + 3'd1;
    assign bases_cnt  = (remaining_reg >= LENGTH_WIDTH'(4)) ? 3'd4 : 3'(remaining_reg);
    assign bases_last = (remaining_reg <= LENGTH_WIDTH'(4));
    assign pad_mask   = ~base_keep_mask(bases_cnt);
    // Lengths that do not fit the length counter are rejected like out-of-range ones.
    assign len_bad    = ((start_len >> LENGTH_WIDTH) != 32'd0) ||
                        (start_len > max_len_reg) || (start_len < min_len_reg);

    always_comb begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        remaining_next = remaining_reg;
        ref_flag_next  = ref_flag_reg;
        saved_id_next  = saved_id_reg;
        category_next  = category_reg;
        halted_next    = halted_reg;
        do_start       = 1'b0;
        start_len      = 32'd0;
        do_fail        = 1'b0;
        fail_code      = ERR_NONE;
        emit           = 1'b0;
        entry          = '0;

        if (accept && !halted_reg) begin
            if (stream_end) begin
                if (phase_reg == PH_CONTROL) begin
                    emit       = 1'b1;
                    entry.kind = KIND_END;
                end
                else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end
            end
            else begin
                unique case (phase_reg)
                    PH_LENGTH, PH_CATEGORY: begin
                        acc_next = acc_merged;
                        idx_next = idx_inc;
                        if (idx_inc == 3'd4) begin
                            if (phase_reg == PH_LENGTH) begin
                                do_start  = 1'b1;
                                start_len = acc_merged;
                            end
                            else if (acc_merged > {24'd0, max_cat_reg}) begin
                                do_fail   = 1'b1;
                                fail_code = ERR_CATEGORY;
                            end
                            else begin
                                category_next = acc_merged[7:0];
                                phase_next    = PH_CONTROL;
                                idx_next      = 3'd0;
                                acc_next      = 32'd0;
                                emit          = 1'b1;
                                entry.kind    = KIND_CATEGORY;
                            end
                        end
                    end
                    PH_BASES: begin
                        if (bases_last && (bases_cnt != 3'd4) &&
                            ((data_byte & pad_mask) != (PAD_PATTERN & pad_mask))) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_PADDING;
                        end
                        else begin
                            remaining_next = remaining_reg - LENGTH_WIDTH'(bases_cnt);
                            if (bases_last) begin
                                idx_next   = 3'd0;
                                acc_next   = 32'd0;
                                phase_next = ref_flag_reg ? PH_REFERENCE : PH_CONTROL;
                            end
                            emit        = 1'b1;
                            entry.kind  = KIND_BASES;
                            entry.data  = data_byte;
                            entry.count = bases_cnt;
                            entry.last  = bases_last && !ref_flag_reg;
                        end
                    end
                    PH_REFERENCE: begin
                        // Bytes 0..3 are the reference id, bytes 4..7 the position.
                        idx_next = idx_inc;
                        if (idx_inc == 3'd4) begin
                            saved_id_next = acc_merged;
                            acc_next      = 32'd0;
                        end
                        else if (idx_inc != 3'd0) begin
                            acc_next = acc_merged;
                        end
                        else begin
                            acc_next      = 32'd0;
                            phase_next    = PH_CONTROL;
                            emit          = 1'b1;
                            entry.kind    = KIND_REF;
                            entry.last    = 1'b1;
                            entry.ref_id  = saved_id_reg;
                            entry.ref_pos = acc_merged;
                        end
                    end
                    PH_CONTROL: begin
                        idx_next      = 3'd0;
                        acc_next      = 32'd0;
                        ref_flag_next = 1'b0;
                        if (!data_byte[7]) begin
                            do_start  = 1'b1;
                            start_len = {25'd0, data_byte[6:0]};
                        end
                        else if (!data_byte[6]) begin
                            ref_flag_next = data_byte[5];
                            phase_next    = PH_LENGTH;
                        end
                        else begin
                            phase_next = PH_CATEGORY;
                        end
                    end
                    default: begin
                        phase_next = PH_CONTROL;
                    end
                endcase
            end

            if (do_start) begin
                if (len_bad) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_LENGTH;
                end
                else begin
                    remaining_next = start_len[LENGTH_WIDTH-1:0];
                    idx_next       = 3'd0;
                    acc_next       = 32'd0;
                    if (start_len != 32'd0) begin
                        phase_next = PH_BASES;
                    end
                    else if (ref_flag_next) begin
                        phase_next = PH_REFERENCE;
                    end
                    else begin
                        phase_next = PH_CONTROL;
                    end
                    emit          = 1'b1;
                    entry.kind    = KIND_START;
                    entry.length  = start_len;
                    entry.has_ref = ref_flag_next;
                    entry.last    = (start_len == 32'd0) && !ref_flag_next;
                end
            end

            if (do_fail) begin
                halted_next    = 1'b1;
                phase_next     = PH_CONTROL;
                emit           = 1'b1;
                entry          = '0;
                entry.kind     = KIND_ERROR;
                entry.err_code = fail_code;
            end
        end

        entry.category = category_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg     <= PH_CONTROL;
            idx_reg       <= '0;
            acc_reg       <= '0;
            remaining_reg <= '0;
            ref_flag_reg  <= 1'b0;
            saved_id_reg  <= '0;
            category_reg  <= '0;
            halted_reg    <= 1'b0;
        end
        else begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            remaining_reg <= remaining_next;
            ref_flag_reg  <= ref_flag_next;
            saved_id_reg  <= saved_id_next;
            category_reg  <= category_next;
            halted_reg    <= halted_next;
        end
    end

    assign q_push  = emit;
    assign q_entry = entry;

endmodule

// ===== hw/rtl/pdrd_queue.sv =====
// Short queue of classified items between the parser and the output stage.
// Depends on pdrd_pkg for the entry type and depth.
module pdrd_queue
    import pdrd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wr_entry,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output entry_t rd_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/pdrd_back.sv =====
// Output stage of the packed DNA record decoder: turns a queued item into the
// result fields and holds it in a register until it is popped. Depends on pdrd_pkg.
module pdrd_back
    import pdrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  entry_t             q_entry,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [2:0]         result_kind,
    output logic [31:0]        read_length,
    output logic               has_reference,
    output logic [7:0]         bases,
    output logic [2:0]         base_count,
    output logic               last_of_read,
    output logic [7:0]         category,
    output logic signed [31:0] reference_id,
    output logic signed [31:0] reference_pos,
    output logic [2:0]         error_code
);

    logic        out_valid_reg, out_valid_next;
    logic        load;
    logic [2:0]  kind_reg;
    logic [31:0] length_reg;
    logic        has_ref_reg;
    logic [7:0]  bases_reg;
    logic [2:0]  count_reg;
    logic        last_reg;
    logic [7:0]  category_reg;
    logic [31:0] ref_id_reg;
    logic [31:0] ref_pos_reg;
    logic [2:0]  err_reg;
    logic        is_start;
    logic        is_bases;
    logic        is_ref;
    logic        is_error;

    // The output register refills in the same cycle that its item is popped.
    assign load  = !q_empty && (!out_valid_reg || pop);
    assign q_pop = load;

    assign is_start = (q_entry.kind == KIND_START);
    assign is_bases = (q_entry.kind == KIND_BASES);
    assign is_ref   = (q_entry.kind == KIND_REF);
    assign is_error = (q_entry.kind == KIND_ERROR);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            kind_reg     <= q_entry.kind;
            length_reg   <= is_start ? q_entry.length : 32'd0;
            has_ref_reg  <= is_start && q_entry.has_ref;
            bases_reg    <= is_bases ? (q_entry.data & base_keep_mask(q_entry.count)) : 8'd0;
            count_reg    <= is_bases ? q_entry.count : 3'd0;
            last_reg     <= q_entry.last;
            category_reg <= q_entry.category;
            ref_id_reg   <= is_ref ? q_entry.ref_id : 32'd0;
            ref_pos_reg  <= is_ref ? q_entry.ref_pos : 32'd0;
            err_reg      <= is_error ? q_entry.err_code : ERR_NONE;
        end
    end

    assign empty         = !out_valid_reg;
    assign result_kind   = kind_reg;
    assign read_length   = length_reg;
    assign has_reference = has_ref_reg;
    assign bases         = bases_reg;
    assign base_count    = count_reg;
    assign last_of_read  = last_reg;
    assign category      = category_reg;
    assign reference_id  = signed'(ref_id_reg);
    assign reference_pos = signed'(ref_pos_reg);
    assign error_code    = err_reg;

endmodule

// ===== hw/rtl/pdrd_checker.sv =====
// Port-level checks for the packed DNA record decoder, bound to its top level.
// Depends on pdrd_pkg and packed_dna_record_decoder.
module pdrd_checker
    import pdrd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  result_kind,
    input logic [7:0]  bases,
    input logic [2:0]  base_count,
    input logic        last_of_read,
    input logic [2:0]  error_code
);

    // A waiting result must not change until it is popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(bases)))
        else $error("waiting result changed before it was popped");

    // Bases items carry one to four bases and nothing beyond them.
    a_bases: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_BASES) |->
        (base_count != 3'd0 && base_count <= 3'd4 &&
         (bases & ~base_keep_mask(base_count)) == 8'd0))
        else $error("bases item with bad count or stray bits");

    // An error code shows up exactly on error items.
    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result_kind == KIND_ERROR) ==
                    (error_code != ERR_NONE && error_code <= ERR_TRUNCATED)))
        else $error("error code does not match the item kind");

    // Reference info always closes its record.
    a_ref_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_REF) |-> last_of_read)
        else $error("reference info item not marked as last of record");

endmodule

bind packed_dna_record_decoder pdrd_checker u_pdrd_checker (.*);
